[src/assert_macros.svh]
// Assertion macros used by the interval set RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// Check that a trigger is followed by a condition in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed: implication does not hold");

// Check that a trigger is followed by a condition in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle implication does not hold");

`endif

[src/isie_pkg.sv]
// Package with types and constants of the interval set block
`timescale 1ns / 1ps

package isie_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int FRAME_BITS_DEF  = 24;
    localparam int FIELD_BITS      = 24;
    localparam int POS_BITS        = 9;

    typedef enum logic [1:0] {
        CMD_INCLUDE = 2'd0,
        CMD_EXCLUDE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC_SCAN,
        S_INC_MERGE,
        S_EXC_EMPTY1,
        S_EXC_EMPTY2,
        S_EXC_SCAN,
        S_EXC_CUT,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_COMMIT,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SET_START
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [POS_BITS-1:0]   pos;
        logic                  merge;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [FIELD_BITS-1:0] range_start;
        logic [FIELD_BITS-1:0] range_stop;
        logic                  stop_open;
        logic [3:0]            read_index;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [4:0]            entry_count;
        logic [FIELD_BITS-1:0] entry_start;
        logic [FIELD_BITS-1:0] entry_stop;
        logic                  entry_stop_open;
    } rsp_item_t;

endpackage

[src/isie_cell.sv]
// One table cell: a working entry that shifts with its neighbors and a kept entry
`timescale 1ns / 1ps

module isie_cell #(
    parameter int FW  = 24,
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  isie_pkg::cell_ctrl_t ctrl,
    input  logic [FW-1:0]        wr_st,
    input  logic [FW-1:0]        wr_en,
    input  logic                 wr_op,
    input  logic [FW-1:0]        left_st,
    input  logic [FW-1:0]        left_en,
    input  logic                 left_op,
    input  logic [FW-1:0]        right_st,
    input  logic [FW-1:0]        right_en,
    input  logic                 right_op,
    output logic [FW-1:0]        work_st,
    output logic [FW-1:0]        work_en,
    output logic                 work_op,
    output logic [FW-1:0]        keep_st,
    output logic [FW-1:0]        keep_en,
    output logic                 keep_op
);
    import isie_pkg::*;

    localparam logic [POS_BITS-1:0] MY_POS   = POS_BITS'(IDX);
    localparam logic [POS_BITS-1:0] NEXT_POS = POS_BITS'(IDX + 1);

    logic [FW-1:0] work_st_reg, work_st_next;
    logic [FW-1:0] work_en_reg, work_en_next;
    logic          work_op_reg, work_op_next;
    logic [FW-1:0] keep_st_reg, keep_st_next;
    logic [FW-1:0] keep_en_reg, keep_en_next;
    logic          keep_op_reg, keep_op_next;

    // Pick the next working and kept entry from the broadcast operation
    always_comb
    begin
        work_st_next = work_st_reg;
        work_en_next = work_en_reg;
        work_op_next = work_op_reg;
        keep_st_next = keep_st_reg;
        keep_en_next = keep_en_reg;
        keep_op_next = keep_op_reg;
        case (ctrl.op)
            CELL_LOAD:
            begin
                work_st_next = keep_st_reg;
                work_en_next = keep_en_reg;
                work_op_next = keep_op_reg;
            end
            CELL_COMMIT:
            begin
                keep_st_next = work_st_reg;
                keep_en_next = work_en_reg;
                keep_op_next = work_op_reg;
            end
            CELL_INSERT:
            begin
                if (MY_POS > ctrl.pos)
                begin
                    work_st_next = left_st;
                    work_en_next = left_en;
                    work_op_next = left_op;
                end
                else if (MY_POS == ctrl.pos)
                begin
                    work_st_next = wr_st;
                    work_en_next = wr_en;
                    work_op_next = wr_op;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_POS >= ctrl.pos)
                begin
                    work_st_next = right_st;
                    work_en_next = right_en;
                    work_op_next = right_op;
                end
                else if (ctrl.merge && NEXT_POS == ctrl.pos)
                begin
                    work_en_next = wr_en;
                    work_op_next = wr_op;
                end
            end
            CELL_SET_START:
            begin
                if (MY_POS == ctrl.pos)
                begin
                    work_st_next = wr_st;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the entries
    always_ff @(posedge clk)
    begin
        work_st_reg <= work_st_next;
        work_en_reg <= work_en_next;
        work_op_reg <= work_op_next;
        keep_st_reg <= keep_st_next;
        keep_en_reg <= keep_en_next;
        keep_op_reg <= keep_op_next;
    end

    assign work_st = work_st_reg;
    assign work_en = work_en_reg;
    assign work_op = work_op_reg;
    assign keep_st = keep_st_reg;
    assign keep_en = keep_en_reg;
    assign keep_op = keep_op_reg;

endmodule

[src/interval_set_include_exclude_core.sv]
// Top level of the sorted disjoint interval set with include and exclude commands
// The block holds up to TABLE_DEPTH sorted, disjoint, inclusive frame ranges in a row of
// cells; the last range may run open to the end. One command is worked at a time and
// gives one response. Include and exclude walk the row one step at a time, where a step
// passes, splits, trims or removes one entry, inserts a new one, or finds where the walk
// stops. Every insert or remove shifts the whole row at once. The command port stalls
// while a command is being worked and accepts the next one as soon as the response sits
// in the output register.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module interval_set_include_exclude_core #(
    parameter int TABLE_DEPTH = isie_pkg::TABLE_DEPTH_DEF,
    parameter int FRAME_BITS  = isie_pkg::FRAME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  isie_pkg::cmd_item_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output isie_pkg::rsp_item_t rsp
);
    import isie_pkg::*;

    localparam int FW    = FRAME_BITS;
    localparam int FW1   = FRAME_BITS + 1;
    localparam int CELLS = TABLE_DEPTH + 2;
    localparam int CW    = $clog2(CELLS);
    localparam int IW    = $clog2(CELLS + 1);
    localparam int WIDE  = (FW > FIELD_BITS) ? FW : FIELD_BITS;

    state_t        state_reg, state_next;
    logic [1:0]    cmd_reg;
    logic [FW-1:0] a_reg;
    logic [FW-1:0] b_reg;
    logic          o_reg;
    logic [3:0]    idx_reg;
    logic [IW-1:0] n_reg, n_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] total_reg, total_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_item_t     rsp_reg;

    cell_ctrl_t    ctrl;
    logic [FW-1:0] wr_st;
    logic [FW-1:0] wr_en;
    logic          wr_op;

    logic [FW-1:0] work_st [CELLS];
    logic [FW-1:0] work_en [CELLS];
    logic          work_op [CELLS];
    logic [FW-1:0] keep_st [CELLS];
    logic [FW-1:0] keep_en [CELLS];
    logic          keep_op [CELLS];

    logic [WIDE-1:0] a_wide;
    logic [WIDE-1:0] b_wide;
    logic [FW-1:0]   a_in;
    logic [FW-1:0]   b_in;
    logic [FW-1:0]   a_ord;
    logic [FW-1:0]   b_ord;

    logic            accept;
    logic            rsp_free;
    logic            rsp_load;
    logic [CW-1:0]   i_idx;
    logic [FW-1:0]   cur_st;
    logic [FW-1:0]   cur_en;
    logic            cur_op;
    logic            at_end;
    logic            a_lt_st;
    logic            a_le_st;
    logic            a_le_en;
    logic            a_le_en1;
    logic            b1_lt_st;
    logic            b_lt_st;
    logic            b_lt_en;
    logic            b_max;
    logic            over_full;
    logic            idx_ok;
    logic [CW-1:0]   rd_idx;
    logic [WIDE-1:0] rd_st_wide;
    logic [WIDE-1:0] rd_en_wide;
    rsp_item_t       rsp_new;

    // Mask the bounds to the frame width, then order them
    assign a_wide = WIDE'(cmd.range_start);
    assign b_wide = WIDE'(cmd.range_stop);
    assign a_in   = a_wide[FW-1:0];
    assign b_in   = b_wide[FW-1:0];

    always_comb
    begin
        a_ord = a_in;
        b_ord = b_in;
        if (cmd.stop_open)
        begin
            b_ord = '0;
        end
        else if (b_in < a_in)
        begin
            a_ord = b_in;
            b_ord = a_in;
        end
    end

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_load  = (state_reg == S_FINISH) && rsp_free;

    // Look at the entry under the walk pointer
    assign i_idx  = i_reg[CW-1:0];
    assign cur_st = work_st[i_idx];
    assign cur_en = work_en[i_idx];
    assign cur_op = work_op[i_idx];

    assign at_end    = (i_reg >= n_reg);
    assign a_lt_st   = (a_reg < cur_st);
    assign a_le_st   = (a_reg <= cur_st);
    assign a_le_en   = (a_reg <= cur_en);
    assign a_le_en1  = ({1'b0, a_reg} <= ({1'b0, cur_en} + FW1'(1)));
    assign b1_lt_st  = (({1'b0, b_reg} + FW1'(1)) < {1'b0, cur_st});
    assign b_lt_st   = (b_reg < cur_st);
    assign b_lt_en   = (b_reg < cur_en);
    assign b_max     = (b_reg == '1);
    assign over_full = (n_reg > IW'(TABLE_DEPTH));

    // Next state of the command sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.cmd == CMD_INCLUDE)
                    begin
                        state_next = S_INC_SCAN;
                    end
                    else if (cmd.cmd == CMD_EXCLUDE)
                    begin
                        state_next = (total_reg == '0) ? S_EXC_EMPTY1 : S_EXC_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_INC_SCAN:
            begin
                if (at_end || (!a_lt_st && cur_op))
                begin
                    state_next = S_FINISH;
                end
                else if (a_lt_st || a_le_en1)
                begin
                    state_next = o_reg ? S_FINISH : S_INC_MERGE;
                end
            end
            S_INC_MERGE:
            begin
                if (at_end || b1_lt_st)
                begin
                    state_next = S_FINISH;
                end
            end
            S_EXC_EMPTY1:
            begin
                state_next = S_EXC_EMPTY2;
            end
            S_EXC_EMPTY2:
            begin
                state_next = S_FINISH;
            end
            S_EXC_SCAN:
            begin
                if (at_end)
                begin
                    state_next = S_FINISH;
                end
                else if (a_le_st || cur_op || a_le_en)
                begin
                    state_next = o_reg ? S_FINISH : S_EXC_CUT;
                end
            end
            S_EXC_CUT:
            begin
                if (at_end || b_lt_st || cur_op || b_lt_en)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drive the cell row and the counters for each state
    always_comb
    begin
        ctrl.op    = CELL_HOLD;
        ctrl.pos   = POS_BITS'(i_reg);
        ctrl.merge = 1'b0;
        wr_st      = a_reg;
        wr_en      = o_reg ? '0 : b_reg;
        wr_op      = o_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        total_next = total_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.op = CELL_LOAD;
                    n_next  = total_reg;
                    i_next  = '0;
                end
            end
            S_INC_SCAN:
            begin
                if (at_end)
                begin
                    ctrl.op  = CELL_INSERT;
                    ctrl.pos = POS_BITS'(n_reg);
                    n_next   = n_reg + IW'(1);
                end
                else if (a_lt_st || (!cur_op && a_le_en1))
                begin
                    ctrl.op = CELL_INSERT;
                    if (!a_lt_st)
                    begin
                        wr_st = cur_st;
                    end
                    i_next = i_reg + IW'(1);
                    n_next = o_reg ? (i_reg + IW'(1)) : (n_reg + IW'(1));
                end
                else if (!cur_op)
                begin
                    i_next = i_reg + IW'(1);
                end
            end
            S_INC_MERGE:
            begin
                if (!at_end && !b1_lt_st)
                begin
                    ctrl.op    = CELL_REMOVE;
                    ctrl.merge = cur_op || b_lt_en;
                    wr_en      = cur_en;
                    wr_op      = cur_op;
                    n_next     = n_reg - IW'(1);
                end
            end
            S_EXC_EMPTY1:
            begin
                // Keep everything after the cut
                if (!o_reg && !b_max)
                begin
                    ctrl.op  = CELL_INSERT;
                    ctrl.pos = '0;
                    wr_st    = b_reg + FW'(1);
                    wr_en    = '0;
                    wr_op    = 1'b1;
                    n_next   = n_reg + IW'(1);
                end
            end
            S_EXC_EMPTY2:
            begin
                // Keep everything before the cut
                if (a_reg != '0)
                begin
                    ctrl.op  = CELL_INSERT;
                    ctrl.pos = '0;
                    wr_st    = '0;
                    wr_en    = a_reg - FW'(1);
                    wr_op    = 1'b0;
                    n_next   = n_reg + IW'(1);
                end
            end
            S_EXC_SCAN:
            begin
                if (!at_end)
                begin
                    if (a_le_st)
                    begin
                        if (o_reg)
                        begin
                            n_next = i_reg;
                        end
                    end
                    else if (cur_op || a_le_en)
                    begin
                        // Split off the part in front of the cut
                        ctrl.op = CELL_INSERT;
                        wr_st   = cur_st;
                        wr_en   = a_reg - FW'(1);
                        wr_op   = 1'b0;
                        i_next  = i_reg + IW'(1);
                        n_next  = o_reg ? (i_reg + IW'(1)) : (n_reg + IW'(1));
                    end
                    else
                    begin
                        i_next = i_reg + IW'(1);
                    end
                end
            end
            S_EXC_CUT:
            begin
                if (!at_end && !b_lt_st)
                begin
                    if ((cur_op || b_lt_en) && !b_max)
                    begin
                        ctrl.op = CELL_SET_START;
                        wr_st   = b_reg + FW'(1);
                    end
                    else
                    begin
                        ctrl.op = CELL_REMOVE;
                        n_next  = n_reg - IW'(1);
                    end
                end
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    if ((cmd_reg == CMD_INCLUDE || cmd_reg == CMD_EXCLUDE) && !over_full)
                    begin
                        ctrl.op    = CELL_COMMIT;
                        total_next = n_reg;
                    end
                    else if (cmd_reg == CMD_CLEAR)
                    begin
                        total_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Row of cells, each handing its entry to both neighbors
    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        logic [FW-1:0] l_st;
        logic [FW-1:0] l_en;
        logic          l_op;
        logic [FW-1:0] r_st;
        logic [FW-1:0] r_en;
        logic          r_op;

        if (g == 0)
        begin : g_first
            assign l_st = '0;
            assign l_en = '0;
            assign l_op = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_st = work_st[g-1];
            assign l_en = work_en[g-1];
            assign l_op = work_op[g-1];
        end

        if (g == CELLS - 1)
        begin : g_last
            assign r_st = '0;
            assign r_en = '0;
            assign r_op = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_st = work_st[g+1];
            assign r_en = work_en[g+1];
            assign r_op = work_op[g+1];
        end

        isie_cell #(
            .FW  (FW),
            .IDX (g)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .wr_st    (wr_st),
            .wr_en    (wr_en),
            .wr_op    (wr_op),
            .left_st  (l_st),
            .left_en  (l_en),
            .left_op  (l_op),
            .right_st (r_st),
            .right_en (r_en),
            .right_op (r_op),
            .work_st  (work_st[g]),
            .work_en  (work_en[g]),
            .work_op  (work_op[g]),
            .keep_st  (keep_st[g]),
            .keep_en  (keep_en[g]),
            .keep_op  (keep_op[g])
        );
    end

    // Build the response
    assign idx_ok     = (32'(idx_reg) < 32'(total_reg));
    assign rd_idx     = CW'(idx_reg);
    assign rd_st_wide = WIDE'(keep_st[rd_idx]);
    assign rd_en_wide = WIDE'(keep_en[rd_idx]);

    always_comb
    begin
        rsp_new                 = '0;
        rsp_new.status          = ST_OK;
        rsp_new.entry_count     = 5'(total_next);
        case (cmd_reg)
            CMD_INCLUDE, CMD_EXCLUDE:
            begin
                if (over_full)
                begin
                    rsp_new.status = ST_FULL;
                end
            end
            CMD_READ:
            begin
                if (!idx_ok)
                begin
                    rsp_new.status = ST_RANGE;
                end
                else
                begin
                    rsp_new.entry_start     = rd_st_wide[FIELD_BITS-1:0];
                    rsp_new.entry_stop      = keep_op[rd_idx] ? '0
                                                              : rd_en_wide[FIELD_BITS-1:0];
                    rsp_new.entry_stop_open = keep_op[rd_idx];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Latch the command and the response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd.cmd;
            a_reg   <= a_ord;
            b_reg   <= b_ord;
            o_reg   <= cmd.stop_open;
            idx_reg <= cmd.read_index;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_ALWAYS(a_total_bound, clk, rst_n, total_reg <= IW'(TABLE_DEPTH))
    `ASSERT_IMPLY(a_work_bound, clk, rst_n, state_reg != S_IDLE, n_reg <= IW'(CELLS))
    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, accept, state_reg != S_IDLE)
    `ASSERT_NEXT(a_rsp_after_finish, clk, rst_n, rsp_load, rsp_valid_reg && state_reg == S_IDLE)

endmodule
